### hw/rtl/htpd_pkg.sv
`default_nettype none

package htpd_pkg;

    // Bits in one sensor frame (after the reference edge)
    localparam int FRAME_BITS   = 40;
    localparam int COUNT_W      = $clog2(FRAME_BITS + 1);
    localparam int TIME_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int FRAME_BYTES  = 5;
    localparam int ALERT_W      = 3;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_ONE_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOT_LIMIT          = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DRY_TEMP_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRY_HUMIDITY_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PLEASANT_TEMP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COLD_LIMIT         = 3'd5;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0] RST_BIT_ONE_THRESHOLD  = 16'd110;
    localparam logic [BYTE_W-1:0] RST_HOT_LIMIT          = 8'd45;
    localparam logic [BYTE_W-1:0] RST_DRY_TEMP_LIMIT     = 8'd40;
    localparam logic [BYTE_W-1:0] RST_DRY_HUMIDITY_LIMIT = 8'd20;
    localparam logic [BYTE_W-1:0] RST_PLEASANT_TEMP      = 8'd21;
    localparam logic [BYTE_W-1:0] RST_COLD_LIMIT         = 8'd5;

    // Alert classes, first match wins
    localparam logic [ALERT_W-1:0] ALERT_HOT      = 3'd0;
    localparam logic [ALERT_W-1:0] ALERT_DRY_HOT  = 3'd1;
    localparam logic [ALERT_W-1:0] ALERT_PLEASANT = 3'd2;
    localparam logic [ALERT_W-1:0] ALERT_COLD     = 3'd3;
    localparam logic [ALERT_W-1:0] ALERT_NORMAL   = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0] bit_one_threshold;
        logic [BYTE_W-1:0] hot_limit;
        logic [BYTE_W-1:0] dry_temp_limit;
        logic [BYTE_W-1:0] dry_humidity_limit;
        logic [BYTE_W-1:0] pleasant_temp;
        logic [BYTE_W-1:0] cold_limit;
    } htpd_cfg_t;

    typedef struct packed {
        logic last_edge;   // next accepted edge completes the frame
        logic done;        // frame completes on this beat
    } htpd_frame_stat_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  humidity_whole;
        logic [BYTE_W-1:0]  humidity_frac;
        logic [BYTE_W-1:0]  temp_whole;
        logic [BYTE_W-1:0]  temp_frac;
        logic [BYTE_W-1:0]  check_byte;
        logic [ALERT_W-1:0] alert_class;
    } htpd_result_t;

endpackage

`default_nettype wire

### hw/rtl/htpd_frame.sv
`default_nettype none

module htpd_frame
    import htpd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [TIME_W-1:0]     capture_time,
    input  wire logic [TIME_W-1:0]     bit_one_threshold,
    output htpd_frame_stat_t           stat,
    output logic      [FRAME_BITS-1:0] frame_word
);

    logic [TIME_W-1:0]     last_capture_reg;
    logic [COUNT_W-1:0]    edge_count_reg;
    logic [FRAME_BITS-1:0] frame_bits_reg;

    logic [TIME_W-1:0]     interval;
    logic                  new_bit;
    logic [FRAME_BITS-1:0] frame_bits_next;

    // Wrap-safe interval: modulo-2^16 subtract
    assign interval        = capture_time - last_capture_reg;
    assign new_bit         = (interval >= bit_one_threshold);
    assign frame_bits_next = {frame_bits_reg[FRAME_BITS-2:0], new_bit};

    assign stat.last_edge = (edge_count_reg == COUNT_W'(FRAME_BITS));
    assign stat.done      = accept && stat.last_edge;
    assign frame_word     = frame_bits_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg <= '0;
            edge_count_reg   <= '0;
            frame_bits_reg   <= '0;
        end
        else if (accept)
        begin
            if (edge_count_reg == '0)
            begin
                last_capture_reg <= capture_time;
                edge_count_reg   <= COUNT_W'(1);
            end
            else if (stat.last_edge)
            begin
                // drop the frame, next edge is a fresh reference
                last_capture_reg <= '0;
                edge_count_reg   <= '0;
                frame_bits_reg   <= '0;
            end
            else
            begin
                last_capture_reg <= capture_time;
                edge_count_reg   <= edge_count_reg + COUNT_W'(1);
                frame_bits_reg   <= frame_bits_next;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/htpd_classify.sv
`default_nettype none

module htpd_classify
    import htpd_pkg::*;
(
    input  wire logic [FRAME_BITS-1:0] frame_word,
    input  wire htpd_cfg_t             cfg,
    output htpd_result_t               result
);

    logic [BYTE_W-1:0] frame_byte [FRAME_BYTES];
    logic [BYTE_W-1:0] hw;
    logic [BYTE_W-1:0] tw;

    // Take bytes from the top of the frame, first byte highest
    for (genvar k = 0; k < FRAME_BYTES; k++)
    begin : g_byte
        if (FRAME_BITS >= BYTE_W * (k + 1))
        begin : g_take
            assign frame_byte[k] = frame_word[FRAME_BITS - BYTE_W * (k + 1) +: BYTE_W];
        end
        else
        begin : g_zero
            assign frame_byte[k] = '0;
        end
    end

    assign hw = frame_byte[0];
    assign tw = frame_byte[2];

    always_comb
    begin
        result.humidity_whole = frame_byte[0];
        result.humidity_frac  = frame_byte[1];
        result.temp_whole     = frame_byte[2];
        result.temp_frac      = frame_byte[3];
        result.check_byte     = frame_byte[4];
        if (tw > cfg.hot_limit)
            result.alert_class = ALERT_HOT;
        else if (tw > cfg.dry_temp_limit && hw < cfg.dry_humidity_limit)
            result.alert_class = ALERT_DRY_HOT;
        else if (tw == cfg.pleasant_temp)
            result.alert_class = ALERT_PLEASANT;
        else if (tw < cfg.cold_limit)
            result.alert_class = ALERT_COLD;
        else
            result.alert_class = ALERT_NORMAL;
    end

endmodule

`default_nettype wire

### hw/rtl/humidity_temp_pulse_decoder_top.sv
// Channel   Direction  Handshake                      Payload
// capture   in         capture_valid / capture_ready  capture_time[15:0]
// result    out        result_valid / result_ready    five data bytes, alert_class[2:0]
// config    in         cfg_wr_en (no wait)            cfg_index[2:0], cfg_wdata[15:0]
//
// One capture beat per cycle while capture_ready is high; the frame state and the
// result register update at the edge that takes the beat, so a result appears in
// the cycle after the beat carrying the frame's final edge (the one that delivers bit 40 of 40).
// Only that final edge waits on the result register: while an earlier result
// is held, captures that complete no frame keep flowing.
// Asynchronous active-low reset clears the frame state, the result valid flag
// and loads the configuration defaults; no clearing pass is needed.
`default_nettype none

module humidity_temp_pulse_decoder_top
    import htpd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   capture_valid,
    output logic                        capture_ready,
    input  wire logic [TIME_W-1:0]      capture_time,

    output logic                        result_valid,
    input  wire logic                   result_ready,
    output logic      [BYTE_W-1:0]      humidity_whole,
    output logic      [BYTE_W-1:0]      humidity_frac,
    output logic      [BYTE_W-1:0]      temp_whole,
    output logic      [BYTE_W-1:0]      temp_frac,
    output logic      [BYTE_W-1:0]      check_byte,
    output logic      [ALERT_W-1:0]     alert_class,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    htpd_cfg_t             cfg_reg;
    htpd_frame_stat_t      frame_stat;
    logic [FRAME_BITS-1:0] frame_word;
    htpd_result_t          result_comb;
    htpd_result_t          result_reg;
    logic                  result_valid_reg;
    logic                  capture_accept;

    // Hold the final edge back only while an untaken result fills the register
    assign capture_ready  = !(frame_stat.last_edge && result_valid_reg && !result_ready);
    assign capture_accept = capture_valid && capture_ready;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_one_threshold  <= RST_BIT_ONE_THRESHOLD;
            cfg_reg.hot_limit          <= RST_HOT_LIMIT;
            cfg_reg.dry_temp_limit     <= RST_DRY_TEMP_LIMIT;
            cfg_reg.dry_humidity_limit <= RST_DRY_HUMIDITY_LIMIT;
            cfg_reg.pleasant_temp      <= RST_PLEASANT_TEMP;
            cfg_reg.cold_limit         <= RST_COLD_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BIT_ONE_THRESHOLD:  cfg_reg.bit_one_threshold  <= cfg_wdata;
                REG_HOT_LIMIT:          cfg_reg.hot_limit          <= cfg_wdata[BYTE_W-1:0];
                REG_DRY_TEMP_LIMIT:     cfg_reg.dry_temp_limit     <= cfg_wdata[BYTE_W-1:0];
                REG_DRY_HUMIDITY_LIMIT: cfg_reg.dry_humidity_limit <= cfg_wdata[BYTE_W-1:0];
                REG_PLEASANT_TEMP:      cfg_reg.pleasant_temp      <= cfg_wdata[BYTE_W-1:0];
                REG_COLD_LIMIT:         cfg_reg.cold_limit         <= cfg_wdata[BYTE_W-1:0];
                default:                ;
            endcase
        end
    end

    // Edge timing and bit shifting
    htpd_frame u_frame (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (capture_accept),
        .capture_time      (capture_time),
        .bit_one_threshold (cfg_reg.bit_one_threshold),
        .stat              (frame_stat),
        .frame_word        (frame_word)
    );

    // Byte split and alert decision on the completed frame
    htpd_classify u_classify (
        .frame_word (frame_word),
        .cfg        (cfg_reg),
        .result     (result_comb)
    );

    // Result valid: set by a completing beat, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (frame_stat.done)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    // Result payload: load only on a completing beat
    always_ff @(posedge clk)
    begin
        if (frame_stat.done)
            result_reg <= result_comb;
    end

    assign result_valid   = result_valid_reg;
    assign humidity_whole = result_reg.humidity_whole;
    assign humidity_frac  = result_reg.humidity_frac;
    assign temp_whole     = result_reg.temp_whole;
    assign temp_frac      = result_reg.temp_frac;
    assign check_byte     = result_reg.check_byte;
    assign alert_class    = result_reg.alert_class;

endmodule

`default_nettype wire

### hw/rtl/htpd_checker.sv
`default_nettype none

module htpd_checker
    import htpd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               capture_valid,
    input wire logic               capture_ready,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire logic [BYTE_W-1:0]  humidity_whole,
    input wire logic [BYTE_W-1:0]  temp_whole,
    input wire logic [BYTE_W-1:0]  check_byte,
    input wire logic [ALERT_W-1:0] alert_class
);

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid
            && $stable(humidity_whole) && $stable(temp_whole)
            && $stable(check_byte) && $stable(alert_class))
        else $error("result beat changed while stalled");

    // A new result only follows a capture beat
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid && !result_ready)
            |-> $past(capture_valid && capture_ready))
        else $error("result appeared without a capture beat");

    // Capture stalls only behind a held result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !capture_ready |-> result_valid && !result_ready)
        else $error("capture stalled with free result register");

    // Alert class stays in its coded range
    a_alert_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alert_class <= ALERT_NORMAL)
        else $error("alert class out of range");

endmodule

bind humidity_temp_pulse_decoder_top htpd_checker u_htpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .capture_valid  (capture_valid),
    .capture_ready  (capture_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .humidity_whole (humidity_whole),
    .temp_whole     (temp_whole),
    .check_byte     (check_byte),
    .alert_class    (alert_class)
);

`default_nettype wire
